FILE: sv/corrected_jet_invariant_mass_assert.svh
// Assertion macros shared by the jet invariant mass block
`ifndef CORRECTED_JET_INVARIANT_MASS_ASSERT_SVH
`define CORRECTED_JET_INVARIANT_MASS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CJIM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication
`define CJIM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define CJIM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define CJIM_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/cjim_pkg.sv
// Types, constants and saturating arithmetic helpers for the jet invariant mass block
`timescale 1ns / 1ps

package cjim_pkg;

    localparam int MAX_JETS_ACCEPTED  = 3;
    localparam int MAX_JETS_PER_EVENT = 32;
    localparam int JET_CAP_INT = (MAX_JETS_PER_EVENT > 63) ? 63 : MAX_JETS_PER_EVENT;

    localparam logic [5:0] JET_CAP = 6'(JET_CAP_INT);
    localparam logic [5:0] MAX_ACC = 6'(MAX_JETS_ACCEPTED);

    localparam logic [23:0]        CUT_RESET = 24'd1280;
    localparam logic signed [47:0] Q44_ONE   = 48'sh1000_0000_0000;
    localparam logic [47:0]        S48_MAX   = 48'h7FFF_FFFF_FFFF;

    // 20^2 and 150^2 GeV^2 in Q.16
    localparam logic [63:0] M2_LOW  = 64'd26214400;
    localparam logic [63:0] M2_HIGH = 64'd1474560000;

    // configuration register indexes
    localparam logic [2:0] CFG_ENERGY_CUT = 3'd0;
    localparam logic [2:0] CFG_MODE       = 3'd1;
    localparam logic [2:0] CFG_COEF_ZERO  = 3'd2;
    localparam logic [2:0] CFG_COEF_ONE   = 3'd3;
    localparam logic [2:0] CFG_COEF_TWO   = 3'd4;
    localparam logic [2:0] CFG_COEF_THREE = 3'd5;
    localparam logic [2:0] CFG_COEF_FOUR  = 3'd6;
    localparam logic [2:0] CFG_COEF_FIVE  = 3'd7;

    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_MAX_POLY = 3'd6;

    typedef struct packed {
        logic [23:0]        jet_energy;
        logic signed [23:0] jet_px;
        logic signed [23:0] jet_py;
        logic signed [23:0] jet_pz;
        logic               last_jet;
    } t_jet_in;

    typedef struct packed {
        logic [30:0] mass_squared;
        logic [5:0]  jets_used;
    } t_mass_out;

    typedef struct packed {
        logic        start;
        logic [47:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [79:0] product;
    } t_mul_rsp;

    // magnitude product -> shifted, saturated, signed 48-bit value
    function automatic logic signed [47:0] mag_sat(input logic [79:0] prod,
                                                   input logic        shift44,
                                                   input logic        neg);
        logic [79:0] sh;
        logic [47:0] cap;
        logic [47:0] mag;
        sh  = shift44 ? (prod >> 44) : (prod >> 8);
        cap = S48_MAX + {47'd0, neg};
        mag = (sh > {32'd0, cap}) ? cap : sh[47:0];
        return neg ? $signed(48'd0 - mag) : $signed(mag);
    endfunction

    function automatic logic signed [47:0] sat48_add(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic [48:0] t;
        t = {a[47], a} + {b[47], b};
        if (t[48] != t[47]) begin
            return t[48] ? $signed({1'b1, 47'd0}) : $signed(S48_MAX);
        end
        return $signed(t[47:0]);
    endfunction

    function automatic logic signed [31:0] sat32_add(input logic signed [31:0] s,
                                                     input logic signed [47:0] v);
        logic [48:0] t;
        t = {{17{s[31]}}, s} + {v[47], v};
        if (!t[48] && (t[47:31] != 17'd0)) begin
            return $signed({1'b0, {31{1'b1}}});
        end
        if (t[48] && (t[47:31] != {17{1'b1}})) begin
            return $signed({1'b1, 31'd0});
        end
        return $signed(t[31:0]);
    endfunction

endpackage

FILE: sv/corrected_jet_invariant_mass.sv
// Sequencing: each multiply on the shared unit in the jet phase is issued, waited on until
// done and folded in, so a jet takes d+s multiplies: d the polynomial degree, s = 1 for a jet
// under the cut or at the jet cap, 4 otherwise. A last jet adds the squared mass (4 squares).
// Throughput: one jet at a time, set by the single 24x32 multiplier that all steps share.
// Reset (synchronous, active low) loads the register defaults and clears sums and count.
`timescale 1ns / 1ps
`include "corrected_jet_invariant_mass_assert.svh"

module corrected_jet_invariant_mass
    import cjim_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_jet_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_mass_out   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HMUL  = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_HADD  = 4'd3;
    localparam logic [3:0] S_SMUL  = 4'd4;
    localparam logic [3:0] S_SWAIT = 4'd5;
    localparam logic [3:0] S_SADD  = 4'd6;
    localparam logic [3:0] S_MMUL  = 4'd7;
    localparam logic [3:0] S_MWAIT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [1:0] COMP_E = 2'd0;
    localparam logic [1:0] COMP_X = 2'd1;
    localparam logic [1:0] COMP_Y = 2'd2;
    localparam logic [1:0] COMP_Z = 2'd3;

    // configuration
    logic [23:0]        r_cut;
    logic [2:0]         r_mode;
    logic signed [47:0] r_coef [6];

    // event state
    logic [31:0]        r_sum_e;
    logic signed [31:0] r_sum_px;
    logic signed [31:0] r_sum_py;
    logic signed [31:0] r_sum_pz;
    logic [5:0]         r_jet_count;

    // sequencer and working registers
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [2:0]         r_k;
    logic [1:0]         r_j;
    t_jet_in            r_in;
    logic [23:0]        r_e;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_mres;
    logic               r_neg;
    logic [63:0]        r_e2;
    logic [63:0]        r_p2;
    logic               r_out_valid;
    t_mass_out          r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic               in_accept;
    logic               cfg_accept;
    logic               poly_on;
    logic [2:0]         k_init;
    logic [2:0]         k_idx;
    logic [2:0]         coef_idx;
    logic [47:0]        acc_mag;
    logic signed [24:0] comp_v;
    logic [23:0]        comp_mag;
    logic signed [31:0] sum_sel;
    logic [31:0]        x_mag;
    logic signed [47:0] mres_n;
    logic               pass_now;
    logic [48:0]        se;
    logic [63:0]        m2;
    logic               out_ok;
    logic               out_free;
    logic               fin_leave;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_accept = i_cfg_valid && o_cfg_ready;

    assign poly_on  = (r_mode != MODE_NONE) && (r_mode <= MODE_MAX_POLY);
    assign k_init   = poly_on ? (r_mode - 3'd1) : 3'd0;
    assign k_idx    = r_k - 3'd1;
    assign coef_idx = i_cfg_index - CFG_COEF_ZERO;

    assign acc_mag = r_acc[47] ? (48'd0 - r_acc) : r_acc;

    always_comb begin
        case (r_j)
            COMP_E:  comp_v = $signed({1'b0, r_in.jet_energy});
            COMP_X:  comp_v = $signed({r_in.jet_px[23], r_in.jet_px});
            COMP_Y:  comp_v = $signed({r_in.jet_py[23], r_in.jet_py});
            default: comp_v = $signed({r_in.jet_pz[23], r_in.jet_pz});
        endcase
        case (r_j)
            COMP_X:  sum_sel = r_sum_px;
            COMP_Y:  sum_sel = r_sum_py;
            default: sum_sel = r_sum_pz;
        endcase
    end

    assign comp_mag = comp_v[24] ? 24'(25'd0 - comp_v) : comp_v[23:0];
    assign x_mag = (r_j == COMP_E) ? r_sum_e
                 : (sum_sel[31] ? (32'd0 - sum_sel) : sum_sel);

    // operand steering into the shared multiplier
    always_comb begin
        mul_req = '0;
        unique case (r_state)
            S_HMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = acc_mag;
                mul_req.b     = {8'd0, r_e};
            end
            S_SMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = acc_mag;
                mul_req.b     = {8'd0, comp_mag};
            end
            S_MMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = {16'd0, x_mag};
                mul_req.b     = x_mag;
            end
            default: mul_req = '0;
        endcase
    end

    cjim_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Horner steps drop 8 bits, scaling drops 44
    assign mres_n = mag_sat(mul_rsp.product, (r_state == S_SWAIT), r_neg);

    assign pass_now = ($signed(r_mres) >= $signed({24'd0, r_cut})) && (r_jet_count < JET_CAP);
    assign se       = {17'd0, r_sum_e} + {1'b0, r_mres};

    assign m2        = r_e2 - r_p2;
    assign out_ok    = (r_e2 >= r_p2) && (m2 >= M2_LOW) && (m2 <= M2_HIGH)
                       && (r_jet_count <= MAX_ACC);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign fin_leave = (r_state == S_FIN) && (!out_ok || out_free);

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = !in_accept ? S_IDLE : ((k_init != 3'd0) ? S_HMUL : S_SMUL);
            S_HMUL:  n_state = S_HWAIT;
            S_HWAIT: n_state = mul_rsp.done ? S_HADD : S_HWAIT;
            S_HADD:  n_state = (r_k == 3'd1) ? S_SMUL : S_HMUL;
            S_SMUL:  n_state = S_SWAIT;
            S_SWAIT: n_state = mul_rsp.done ? S_SADD : S_SWAIT;
            S_SADD: begin
                if ((r_j == COMP_Z) || ((r_j == COMP_E) && !pass_now)) begin
                    n_state = r_in.last_jet ? S_MMUL : S_IDLE;
                end else begin
                    n_state = S_SMUL;
                end
            end
            S_MMUL:  n_state = S_MWAIT;
            S_MWAIT: n_state = !mul_rsp.done ? S_MWAIT : ((r_j == COMP_Z) ? S_FIN : S_MMUL);
            S_FIN:   n_state = fin_leave ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and event sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cut       <= CUT_RESET;
            r_mode      <= MODE_NONE;
            for (int i = 0; i < 6; i++) begin
                r_coef[i] <= (i == 0) ? Q44_ONE : 48'sd0;
            end
            r_sum_e     <= '0;
            r_sum_px    <= '0;
            r_sum_py    <= '0;
            r_sum_pz    <= '0;
            r_jet_count <= '0;
            r_j         <= COMP_E;
            r_k         <= '0;
        end else begin
            r_state <= n_state;

            // a new beat may replace one leaving in the same cycle
            if (fin_leave && out_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_accept) begin
                unique case (i_cfg_index) inside
                    CFG_ENERGY_CUT: r_cut  <= i_cfg_data[23:0];
                    CFG_MODE:       r_mode <= i_cfg_data[2:0];
                    CFG_COEF_ZERO, CFG_COEF_ONE, CFG_COEF_TWO,
                    CFG_COEF_THREE, CFG_COEF_FOUR, CFG_COEF_FIVE:
                                    r_coef[coef_idx] <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_k <= k_init;
                        r_j <= COMP_E;
                    end
                end
                S_HADD: r_k <= k_idx;
                S_SADD: begin
                    if (r_j == COMP_E) begin
                        if (pass_now) begin
                            r_sum_e     <= (se[48:32] != 17'd0) ? 32'hFFFF_FFFF : se[31:0];
                            r_jet_count <= r_jet_count + 6'd1;
                        end
                    end else if (r_j == COMP_X) begin
                        r_sum_px <= sat32_add(r_sum_px, r_mres);
                    end else if (r_j == COMP_Y) begin
                        r_sum_py <= sat32_add(r_sum_py, r_mres);
                    end else begin
                        r_sum_pz <= sat32_add(r_sum_pz, r_mres);
                    end
                    // the mass pass walks the same component order from the start
                    r_j <= (n_state == S_SMUL) ? (r_j + 2'd1) : COMP_E;
                end
                S_MWAIT: begin
                    if (mul_rsp.done) begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_FIN: begin
                    if (fin_leave) begin
                        r_sum_e     <= '0;
                        r_sum_px    <= '0;
                        r_sum_py    <= '0;
                        r_sum_pz    <= '0;
                        r_jet_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in  <= i_in_data;
            r_e   <= (i_in_data.jet_energy < r_cut) ? r_cut : i_in_data.jet_energy;
            r_acc <= poly_on ? r_coef[k_init] : Q44_ONE;
        end
        if (r_state == S_HMUL) begin
            r_neg <= r_acc[47];
        end
        if (r_state == S_SMUL) begin
            r_neg <= r_acc[47] != comp_v[24];
        end
        if ((r_state == S_HWAIT || r_state == S_SWAIT) && mul_rsp.done) begin
            r_mres <= mres_n;
        end
        if (r_state == S_HADD) begin
            r_acc <= sat48_add(r_mres, r_coef[k_idx]);
        end
        if (r_state == S_MWAIT && mul_rsp.done) begin
            if (r_j == COMP_E) begin
                r_e2 <= mul_rsp.product[63:0];
            end else if (r_j == COMP_X) begin
                r_p2 <= mul_rsp.product[63:0];
            end else begin
                r_p2 <= r_p2 + mul_rsp.product[63:0];
            end
        end
        if (fin_leave && out_ok) begin
            r_out.mass_squared <= m2[30:0];
            r_out.jets_used    <= r_jet_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CJIM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, r_state != S_IDLE)
    `CJIM_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_jet_count <= JET_CAP)
    `CJIM_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, mul_rsp.done,
        r_state == S_HWAIT || r_state == S_SWAIT || r_state == S_MWAIT)
    `CJIM_ASSERT_IMP(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_FIN)

endmodule

FILE: sv/cjim_mul.sv
// Shared 48x32 unsigned multiplier built from one 24x32 multiplier: low part, high part, then sum
`timescale 1ns / 1ps

module cjim_mul
    import cjim_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_HI   = 2'd1;
    localparam logic [1:0] M_SUM  = 2'd2;

    logic [1:0]  r_mstate;
    logic [1:0]  n_mstate;
    logic        r_done;
    logic [23:0] r_a_hi;
    logic [31:0] r_b;
    logic [55:0] r_pp;
    logic [55:0] r_lo;
    logic [79:0] r_prod;

    logic        idle;
    logic [23:0] mul_x;
    logic [31:0] mul_y;
    logic [55:0] mul_p;

    assign idle  = (r_mstate == M_IDLE);
    assign mul_x = idle ? i_req.a[23:0] : r_a_hi;
    assign mul_y = idle ? i_req.b : r_b;
    assign mul_p = mul_x * mul_y;

    always_comb begin
        unique case (r_mstate)
            M_IDLE:  n_mstate = i_req.start ? M_HI : M_IDLE;
            M_HI:    n_mstate = M_SUM;
            M_SUM:   n_mstate = M_IDLE;
            default: n_mstate = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_mstate <= n_mstate;
            r_done   <= (r_mstate == M_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (idle && i_req.start) begin
            r_pp   <= mul_p;
            r_a_hi <= i_req.a[47:24];
            r_b    <= i_req.b;
        end else if (r_mstate == M_HI) begin
            r_lo <= r_pp;
            r_pp <= mul_p;
        end else if (r_mstate == M_SUM) begin
            r_prod <= {24'd0, r_lo} + {r_pp, 24'd0};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_prod;

endmodule

FILE: tb/corrected_jet_invariant_mass_tb.sv
// Self-checking testbench: jet beats against a local mass predictor, with random gaps and stalls
`timescale 1ns / 1ps

module corrected_jet_invariant_mass_tb;
    import cjim_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1830;
    localparam int PHASES       = 14;
    localparam int JET_LIMIT    = (MAX_JETS_PER_EVENT > 63) ? 63 : MAX_JETS_PER_EVENT;

    localparam logic [2:0] MODE_CONST  = 3'd1;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam logic signed [47:0] GAIN_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] GAIN_MIN = 48'sh8000_0000_0000;
    localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_jet_in     in_beat   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_ENERGY_CUT;
    logic [47:0] cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_cfg_ready;
    t_mass_out   o_out_data;

    // predictor copy of registers and event sums
    logic [23:0]        cut_q         = CUT_RESET;
    logic [2:0]         mode_q        = MODE_NONE;
    logic signed [47:0] coef_q [6];
    logic [31:0]        sum_e         = '0;
    logic signed [31:0] sum_px        = '0;
    logic signed [31:0] sum_py        = '0;
    logic signed [31:0] sum_pz        = '0;
    logic [5:0]         jets_in_event = '0;

    t_mass_out          pending_masses [$];
    t_mass_out          want_mass;
    logic signed [47:0] coef_plan [6];
    int unsigned        errors      = 0;
    int unsigned        jets_sent   = 0;
    int unsigned        beats       = 0;
    int unsigned        beats_drawn = 0;
    int unsigned        stall_left  = 0;
    int unsigned        hold_cycles = 0;
    bit                 armed       = 1'b0;
    bit                 idle_on     = 1'b1;

    always #5 i_clk = ~i_clk;

    corrected_jet_invariant_mass i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // (a*b) >> sh on magnitudes, truncated toward zero, clamped to signed 48 bit
    function automatic logic signed [47:0] scale_sat(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int              sh);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] mag;
        logic [47:0]  cap;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = ({64'd0, ua} * {64'd0, ub}) >> sh;
        cap = 48'(GAIN_MAX) + 48'(neg);
        if (mag > {80'd0, cap}) begin
            mag = {80'd0, cap};
        end
        return neg ? $signed(48'd0 - mag[47:0]) : $signed(mag[47:0]);
    endfunction

    function automatic logic signed [47:0] add_sat48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [63:0] t;
        t = a;
        t = t + b;
        if (t > GAIN_MAX) return GAIN_MAX;
        if (t < GAIN_MIN) return GAIN_MIN;
        return t[47:0];
    endfunction

    function automatic logic signed [31:0] add_sat32(input logic signed [31:0] s,
                                                     input logic signed [47:0] v);
        logic signed [63:0] t;
        t = s;
        t = t + v;
        if (t > S32_MAX) return 32'sh7FFF_FFFF;
        if (t < S32_MIN) return 32'sh8000_0000;
        return t[31:0];
    endfunction

    // Horner over the clipped energy; mode 0 and mode seven both mean unity gain
    function automatic logic signed [47:0] jet_gain(input logic [23:0] energy);
        logic [23:0]        e;
        logic signed [47:0] acc;
        int                 k;
        e = (energy < cut_q) ? cut_q : energy;
        if (mode_q == MODE_NONE || mode_q > MODE_MAX_POLY) return Q44_ONE;
        k   = int'(mode_q) - 1;
        acc = coef_q[k];
        while (k > 0) begin
            k--;
            acc = add_sat48(scale_sat(acc, $signed({40'd0, e}), 8), coef_q[k]);
        end
        return acc;
    endfunction

    function automatic void fold_jet(input t_jet_in j);
        logic signed [47:0] gain;
        logic signed [47:0] ce;
        logic signed [63:0] w;
        logic [63:0]        se;
        logic [63:0]        e2;
        logic [63:0]        p2;
        logic [63:0]        m2;
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [63:0]        az;
        t_mass_out          r;
        gain = jet_gain(j.jet_energy);
        ce   = scale_sat($signed({40'd0, j.jet_energy}), gain, 44);
        if (ce >= $signed({24'd0, cut_q}) && jets_in_event < JET_LIMIT) begin
            se            = {16'd0, ce} + {32'd0, sum_e};
            sum_e         = (se > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : se[31:0];
            sum_px        = add_sat32(sum_px, scale_sat($signed(j.jet_px), gain, 44));
            sum_py        = add_sat32(sum_py, scale_sat($signed(j.jet_py), gain, 44));
            sum_pz        = add_sat32(sum_pz, scale_sat($signed(j.jet_pz), gain, 44));
            jets_in_event = jets_in_event + 6'd1;
        end
        if (j.last_jet) begin
            e2 = {32'd0, sum_e} * {32'd0, sum_e};
            w  = sum_px;
            ax = (w < 0) ? -w : w;
            w  = sum_py;
            ay = (w < 0) ? -w : w;
            w  = sum_pz;
            az = (w < 0) ? -w : w;
            p2 = ax * ax + ay * ay + az * az;
            if (e2 >= p2) begin
                m2 = e2 - p2;
                if (m2 >= M2_LOW && m2 <= M2_HIGH && jets_in_event <= MAX_JETS_ACCEPTED) begin
                    r.mass_squared = m2[30:0];
                    r.jets_used    = jets_in_event;
                    pending_masses = {pending_masses, r};
                end
            end
            sum_e         = '0;
            sum_px        = '0;
            sum_py        = '0;
            sum_pz        = '0;
            jets_in_event = '0;
        end
    endfunction

    function automatic logic signed [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic logic [23:0] pick24();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_jet_in mk_jet(input logic [23:0] e, input logic [23:0] px,
                                       input logic [23:0] py, input logic [23:0] pz,
                                       input logic last);
        t_jet_in j;
        j.jet_energy = e;
        j.jet_px     = px;
        j.jet_py     = py;
        j.jet_pz     = pz;
        j.last_jet   = last;
        return j;
    endfunction

    // momentum components within +-E/2, so every jet is massive
    function automatic t_jet_in physics_jet(input int e, input logic last);
        int h;
        h = e / 2;
        return mk_jet(24'(e), 24'(int'($urandom_range(0, 2 * h)) - h),
                      24'(int'($urandom_range(0, 2 * h)) - h),
                      24'(int'($urandom_range(0, 2 * h)) - h), last);
    endfunction

    task automatic send_jet(input t_jet_in j);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= j;
        do @(posedge i_clk); while (o_in_stall);
        fold_jet(j);
        jets_sent++;
    endtask

    // wait for every expected result, then let a jet with no result finish
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_masses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ENERGY_CUT: cut_q = val[23:0];
            CFG_MODE:       mode_q = val[2:0];
            default:        coef_q[idx - CFG_COEF_ZERO] = val;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [23:0] cut, input logic [2:0] mode);
        settle();
        write_reg(CFG_ENERGY_CUT, {24'd0, cut});
        write_reg(CFG_MODE, {45'd0, mode});
        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_COEF_ZERO + 3'(k), coef_plan[k]);
        end
    endtask

    task automatic send_event(input int n, input logic heavy);
        t_jet_in j;
        int      e;
        logic    pos;
        pos = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if (heavy) begin
                // drives the sums into saturation under a large gain
                j = mk_jet(24'($urandom_range(24'h800000, 24'hFFFFFF)),
                           pos ? 24'h7FFFFF : 24'h800000, pos ? 24'h7FFFFF : 24'h800000,
                           pos ? 24'h7FFFFF : 24'h800000, 1'b0);
            end else begin
                e = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 1279)
                                                : $urandom_range(2048, 15360);
                j = physics_jet(e, 1'b0);
            end
            j.last_jet = (i == n - 1);
            send_jet(j);
        end
    endtask

    task automatic run_mix(input int unsigned items);
        int unsigned goal;
        t_jet_in     j;
        goal = jets_sent + items;
        while (jets_sent < goal) begin
            case ($urandom_range(0, 39))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    j = mk_jet(pick24(), pick24(), pick24(), pick24(),
                               $urandom_range(0, 3) == 0);
                    send_jet(j);
                end
                8: send_event($urandom_range(30, 40), $urandom_range(0, 1));
                default: send_event(($urandom_range(0, 5) == 0) ? 4 : $urandom_range(1, 3),
                                    1'b0);
            endcase
        end
    endtask

    task automatic test_reset_defaults();
        send_jet(mk_jet(24'd1000, 24'd0, 24'd0, 24'd0, 1'b1));   // nothing passes the cut
        send_jet(mk_jet(24'd0, 24'd0, 24'd0, 24'd0, 1'b1));
        send_jet(mk_jet(24'd5120, 24'd0, 24'd0, 24'd0, 1'b1));   // 20 GeV, lower edge
        send_jet(mk_jet(24'd5119, 24'd0, 24'd0, 24'd0, 1'b1));
        send_jet(mk_jet(24'd38400, 24'd0, 24'd0, 24'd0, 1'b1));  // 150 GeV, upper edge
        send_jet(mk_jet(24'd38401, 24'd0, 24'd0, 24'd0, 1'b1));
        send_jet(mk_jet(24'd2560, 24'h7FFFFF, 24'd0, 24'd0, 1'b1));  // negative mass
        send_jet(mk_jet(24'hFFFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1));
        for (int i = 0; i < 3; i++) begin
            send_jet(mk_jet(24'd2560, 24'd0, 24'd0, 24'd0, i == 2));
        end
        // one jet too many for an accepted event
        for (int i = 0; i < 4; i++) begin
            send_jet(mk_jet(24'd2560, 24'd0, 24'd0, 24'd0, i == 3));
        end
    endtask

    task automatic test_correction_cases();
        foreach (coef_plan[k]) coef_plan[k] = GAIN_MAX;
        set_config(CUT_RESET, MODE_UNUSED);
        send_jet(mk_jet(24'd12800, 24'd0, 24'd0, 24'd0, 1'b1));
        send_jet(mk_jet(24'd12800, 24'h001000, 24'hFFF000, 24'd0, 1'b1));

        foreach (coef_plan[k]) coef_plan[k] = '0;
        coef_plan[0] = -Q44_ONE;
        set_config(CUT_RESET, MODE_CONST);
        send_jet(mk_jet(24'd12800, 24'd0, 24'd0, 24'd0, 1'b1));
        set_config(24'd0, MODE_CONST);
        send_jet(mk_jet(24'd0, 24'h000100, 24'd0, 24'd0, 1'b0));
        send_jet(mk_jet(24'd12800, 24'd0, 24'd0, 24'd0, 1'b1));

        foreach (coef_plan[k]) coef_plan[k] = GAIN_MAX;
        set_config(24'hFFFFFF, MODE_MAX_POLY);
        send_jet(mk_jet(24'hFFFFFF, 24'h7FFFFF, 24'd0, 24'd0, 1'b1));
        foreach (coef_plan[k]) coef_plan[k] = GAIN_MIN;
        set_config(24'd0, MODE_MAX_POLY);
        send_jet(mk_jet(24'hFFFFFF, 24'd0, 24'd0, 24'd0, 1'b1));
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            // near-unity gain, terms shrinking with the energy scale
            coef_plan[0] = Q44_ONE + (rand48() >>> 6);
            for (int k = 1; k < 6; k++) begin
                coef_plan[k] = rand48() >>> (3 + 7 * k);
            end
            case (p)
                0: set_config(CUT_RESET, MODE_NONE);
                1, 2, 3, 4, 5, 6:
                    set_config((p == 1) ? 24'd0 : 24'($urandom_range(0, 4096)), 3'(p));
                7: begin
                    foreach (coef_plan[k]) coef_plan[k] = rand48();
                    set_config(CUT_RESET, MODE_UNUSED);
                end
                8: begin
                    foreach (coef_plan[k]) coef_plan[k] = GAIN_MAX;
                    set_config(24'hFFFFFF, MODE_MAX_POLY);
                end
                9: begin
                    foreach (coef_plan[k]) coef_plan[k] = GAIN_MIN;
                    set_config(24'd0, MODE_MAX_POLY);
                end
                10: begin
                    coef_plan[0] = GAIN_MAX;
                    set_config(CUT_RESET, MODE_CONST);
                end
                11: begin
                    coef_plan[0] = -Q44_ONE + (rand48() >>> 6);
                    set_config(24'd0, MODE_CONST);
                end
                12: begin
                    foreach (coef_plan[k]) coef_plan[k] = rand48();
                    set_config(24'($urandom), 3'($urandom_range(0, 7)));
                end
                default: set_config(CUT_RESET, 3'($urandom_range(1, 6)));
            endcase
            idle_on = (p % 5) != 4;
            run_mix(RANDOM_ITEMS / PHASES);
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_hold();
        foreach (coef_plan[k]) coef_plan[k] = (k == 0) ? Q44_ONE : '0;
        set_config(CUT_RESET, MODE_NONE);
        idle_on     = 1'b0;
        hold_cycles = 400;
        for (int i = 0; i < 40; i++) begin
            send_jet(mk_jet(24'($urandom_range(5120, 38400)), 24'd0, 24'd0, 24'd0, 1'b1));
        end
        idle_on = 1'b1;
    endtask

    // draw a wait for each result once it shows up
    always @(negedge i_clk) begin
        if (beats != beats_drawn) begin
            beats_drawn = beats;
            armed       = 1'b0;
        end
        if (o_out_valid === 1'b1 && !armed) begin
            armed      = 1'b1;
            stall_left = idle_on ? $urandom_range(0, 6) : 0;
        end
        if (hold_cycles != 0) begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            beats++;
            if (pending_masses.size() == 0) begin
                $error("unexpected result beat: mass_squared %0d jets_used %0d",
                       o_out_data.mass_squared, o_out_data.jets_used);
                errors++;
            end else begin
                want_mass = pending_masses.pop_front();
                if (o_out_data.mass_squared !== want_mass.mass_squared) begin
                    $error("mass_squared: expected %0d, got %0d",
                           want_mass.mass_squared, o_out_data.mass_squared);
                    errors++;
                end
                if (o_out_data.jets_used !== want_mass.jets_used) begin
                    $error("jets_used: expected %0d, got %0d",
                           want_mass.jets_used, o_out_data.jets_used);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (coef_q[k]) coef_q[k] = (k == 0) ? Q44_ONE : '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_correction_cases();
        test_random_phases();
        test_output_hold();
        settle();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
